/* rtl/tbp_pkg.sv */
// shared types, constants and counter functions of the tournament branch predictor
package tbp_pkg;

	localparam int HIST_BITS   = 11;
	localparam int CFG_BITS    = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_BITS-1:0] HIST_LEN_RESET = CFG_BITS'(HIST_BITS);
	localparam logic [1:0]          CTR_RESET      = 2'b00;
	localparam logic [1:0]          CTR_MAX        = 2'b11;

	typedef struct packed {
		logic [31:0] pc;
		logic        taken;
	} branch_word_t;

	typedef struct packed {
		logic final_prediction;
		logic bimodal_prediction;
		logic gshare_prediction;
		logic chose_gshare;
		logic final_correct;
	} result_word_t;

	typedef logic [CFG_BITS-1:0] cfg_word_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} back_state_t;

	function automatic logic [HIST_BITS-1:0] hist_mask(input logic [CFG_BITS-1:0] len);
		logic [CFG_BITS-1:0]  eff;
		logic [HIST_BITS-1:0] m;
		eff = (len > CFG_BITS'(HIST_BITS)) ? CFG_BITS'(HIST_BITS) : len;
		for (int i = 0; i < HIST_BITS; i++) begin
			m[i] = (CFG_BITS'(i) < eff);
		end
		return m;
	endfunction

	function automatic logic [1:0] ctr_toward_zero(input logic [1:0] c);
		return (c != CTR_RESET) ? c - 2'd1 : CTR_RESET;
	endfunction

	function automatic logic [1:0] ctr_toward_three(input logic [1:0] c);
		return (c != CTR_MAX) ? c + 2'd1 : CTR_MAX;
	endfunction

	function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic taken);
		return taken ? ctr_toward_zero(c) : ctr_toward_three(c);
	endfunction

endpackage

/* rtl/tbp_ifs.sv */
// valid/ready channel interfaces for branch, result and configuration words
interface tbp_branch_if;
	import tbp_pkg::*;
	logic         valid;
	logic         ready;
	branch_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tbp_result_if;
	import tbp_pkg::*;
	logic         valid;
	logic         ready;
	result_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tbp_cfg_if;
	import tbp_pkg::*;
	logic      valid;
	logic      ready;
	cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/tbp_queue.sv */
// small fifo between the front end and the table back end
module tbp_queue #(
	parameter int WIDTH = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import tbp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] data_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/tbp_front.sv */
// front end: accepts branches, keeps the global history and forms table indexes
module tbp_front #(
	parameter int TABLE_INDEX_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tbp_branch_if.sink                    branch,
	tbp_cfg_if.sink                       cfg,
	input  logic                          clear_done,
	input  logic                          q_full,
	output logic                          push,
	output logic [2*TABLE_INDEX_BITS:0]   push_data
);
	import tbp_pkg::*;

	localparam int IW = TABLE_INDEX_BITS;

	logic [CFG_BITS-1:0]  hist_len_q;
	logic [HIST_BITS-1:0] hist_q;
	logic [HIST_BITS-1:0] mask;
	logic [HIST_BITS-1:0] hist_m;
	logic [HIST_BITS-1:0] hist_next;
	logic [31:0]          hist_ext;
	logic [IW-1:0]        bi_idx;
	logic [IW-1:0]        gs_idx;

	assign cfg.ready    = 1'b1;
	assign branch.ready = clear_done && !q_full;
	assign push         = branch.valid && branch.ready;

	always_comb begin
		mask      = hist_mask(hist_len_q);
		hist_m    = hist_q & mask;
		hist_next = {hist_m[HIST_BITS-2:0], branch.data.taken} & mask;
		hist_ext  = 32'(hist_m);
		bi_idx    = branch.data.pc[IW-1:0];
		gs_idx    = branch.data.pc[IW-1:0] ^ hist_ext[IW-1:0];
		push_data = {bi_idx, gs_idx, branch.data.taken};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= HIST_LEN_RESET;
			hist_q     <= '0;
		end else begin
			if (cfg.valid && cfg.ready) hist_len_q <= cfg.data;
			if (push) hist_q <= hist_next;
		end
	end

endmodule

/* rtl/tbp_back.sv */
// back end: counter tables, read-modify-write update and result register
module tbp_back #(
	parameter int TABLE_INDEX_BITS = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [2*TABLE_INDEX_BITS:0] pop_data,
	output logic                        pop,
	output logic                        clear_done,
	tbp_result_if.source                result
);
	import tbp_pkg::*;

	localparam int IW    = TABLE_INDEX_BITS;
	localparam int DEPTH = 2 ** TABLE_INDEX_BITS;

	back_state_t  state_q, state_d;
	logic [IW-1:0] clr_q;

	logic [1:0] bi_mem_q [DEPTH];
	logic [1:0] gs_mem_q [DEPTH];
	logic [1:0] ch_mem_q [DEPTH];

	logic [1:0]    bi_rd_q, gs_rd_q, ch_rd_q;
	logic [IW-1:0] bi_idx_q, gs_idx_q;
	logic          taken_q;

	logic          out_valid_q;
	result_word_t  out_q;

	logic          pop_taken;
	logic [IW-1:0] pop_bi, pop_gs;
	logic          clearing, update_go, we;
	logic [IW-1:0] bi_waddr, gs_waddr;
	logic [1:0]    bi_wdata, gs_wdata, ch_wdata;
	logic          bi_pred, gs_pred, use_gs, fin, bi_ok, gs_ok;
	result_word_t  res_d;

	assign pop_taken = pop_data[0];
	assign pop_gs    = pop_data[IW:1];
	assign pop_bi    = pop_data[2*IW:IW+1];

	assign clearing   = (state_q == BK_CLEAR);
	assign clear_done = !clearing;
	assign pop        = (state_q == BK_IDLE) && !q_empty;
	assign update_go  = (state_q == BK_UPDATE) && (!out_valid_q || result.ready);
	assign we         = clearing || update_go;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_comb begin
		bi_pred = !bi_rd_q[1];
		gs_pred = !gs_rd_q[1];
		use_gs  = !ch_rd_q[1];
		fin     = use_gs ? gs_pred : bi_pred;
		bi_ok   = (bi_pred == taken_q);
		gs_ok   = (gs_pred == taken_q);

		res_d.final_prediction   = fin;
		res_d.bimodal_prediction = bi_pred;
		res_d.gshare_prediction  = gs_pred;
		res_d.chose_gshare       = use_gs;
		res_d.final_correct      = (fin == taken_q);

		bi_waddr = clearing ? clr_q : bi_idx_q;
		gs_waddr = clearing ? clr_q : gs_idx_q;
		if (clearing) begin
			bi_wdata = CTR_RESET;
			gs_wdata = CTR_RESET;
			ch_wdata = CTR_RESET;
		end else begin
			bi_wdata = ctr_train(bi_rd_q, taken_q);
			gs_wdata = ctr_train(gs_rd_q, taken_q);
			if (gs_ok == bi_ok) ch_wdata = ch_rd_q;
			else if (gs_ok) ch_wdata = ctr_toward_zero(ch_rd_q);
			else ch_wdata = ctr_toward_three(ch_rd_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == {IW{1'b1}}) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (pop) state_d = BK_UPDATE;
			end
			BK_UPDATE: begin
				if (update_go) state_d = BK_IDLE;
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + IW'(1);
			if (update_go) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (update_go) out_q <= res_d;
		if (pop) begin
			bi_idx_q <= pop_bi;
			gs_idx_q <= pop_gs;
			taken_q  <= pop_taken;
		end
	end

	// one write and one registered read port per table
	always_ff @(posedge clk) begin
		if (we) begin
			bi_mem_q[bi_waddr] <= bi_wdata;
			gs_mem_q[gs_waddr] <= gs_wdata;
			ch_mem_q[bi_waddr] <= ch_wdata;
		end
		if (pop) begin
			bi_rd_q <= bi_mem_q[pop_bi];
			gs_rd_q <= gs_mem_q[pop_gs];
			ch_rd_q <= ch_mem_q[pop_bi];
		end
	end

endmodule

/* rtl/tournament_branch_predictor.sv */
// top level of the tournament (bimodal plus gshare) branch predictor
//
//   channel  dir  word            fields
//   branch   in   branch_word_t   pc[31:0], taken
//   cfg      in   cfg_word_t      history_length[3:0]
//   result   out  result_word_t   final_prediction, bimodal_prediction,
//                                 gshare_prediction, chose_gshare, final_correct
//
// each branch goes through the back end in order: table read in BK_IDLE, then
// counter update and result load in BK_UPDATE, stalled by result.ready;
// no branch is read until the last one is updated. a clearing pass after reset
// zeroes the tables, branch.ready stays low during it; cfg is always ready
// a four-word queue parts the front end from the table back end
// the result register holds its word while result.ready is low
module tournament_branch_predictor #(
	parameter int TABLE_INDEX_BITS = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	tbp_branch_if.sink   branch,
	tbp_cfg_if.sink      cfg,
	tbp_result_if.source result
);
	import tbp_pkg::*;

	localparam int QW = 2 * TABLE_INDEX_BITS + 1;

	logic          clear_done;
	logic          q_full, q_empty;
	logic          push, pop;
	logic [QW-1:0] push_data, pop_data;

	tbp_front #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.branch     (branch),
		.cfg        (cfg),
		.clear_done (clear_done),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	tbp_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	tbp_back #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.clear_done (clear_done),
		.result     (result)
	);

endmodule

/* rtl/tbp_checker.sv */
// port-level checks of the branch predictor, bound to the top level
module tbp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  br_valid,
	input logic                  br_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input tbp_pkg::result_word_t res_data
);
	import tbp_pkg::*;

	localparam logic [3:0] MAX_OUTST = 4'(QUEUE_DEPTH + 2);

	logic       br_acc, res_acc;
	logic [3:0] outst_q;

	assign br_acc  = br_valid && br_ready;
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (br_acc && !res_acc) begin
			outst_q <= outst_q + 4'd1;
		end else if (res_acc && !br_acc) begin
			outst_q <= outst_q - 4'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> outst_q != 4'd0)
		else $error("result word without a pending branch");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= MAX_OUTST)
		else $error("more branches in flight than storage allows");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.br_valid  (branch.valid),
	.br_ready  (branch.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
